// File: sv/go_back_n_sender_unit_assert.svh
// ----------------------------------------------------------------------------
// go_back_n_sender_unit_assert.svh
// Assertion macros used by the checker file of the Go-Back-N sender.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_UNIT_ASSERT_SVH
`define GO_BACK_N_SENDER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define GBNS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("go_back_n_sender_unit: same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet during reset
`define GBNS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("go_back_n_sender_unit: next-cycle check failed");

`endif

// File: sv/gbns_pkg.sv
// ----------------------------------------------------------------------------
// gbns_pkg
// Types and codes of the Go-Back-N sender: transfer structs, kinds, registers.
// ----------------------------------------------------------------------------
`default_nettype none

package gbns_pkg;

	// Field widths fixed by the channel formats
	localparam int SEQ_BITS     = 16;
	localparam int PAYLOAD_BITS = 32;
	localparam int WSIZE_BITS   = 4;

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;
	localparam logic [WSIZE_BITS-1:0] WINDOW_SIZE_RESET = 4'd4;

	// Command kinds
	localparam logic [1:0] KIND_SEND    = 2'd0;
	localparam logic [1:0] KIND_ACK     = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;

	// Result kinds
	localparam logic [1:0] RES_STATUS = 2'd0;
	localparam logic [1:0] RES_PACKET = 2'd1;
	localparam logic [1:0] RES_TSTART = 2'd2;
	localparam logic [1:0] RES_TSTOP  = 2'd3;

	typedef struct packed {
		logic [1:0]              kind;
		logic [PAYLOAD_BITS-1:0] payload;
		logic [SEQ_BITS-1:0]     ack_number;
		logic                    ack_checksum_ok;
		logic [SEQ_BITS-1:0]     timeout_seq;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]              item_kind;
		logic [SEQ_BITS-1:0]     seq_number;
		logic [PAYLOAD_BITS-1:0] packet_payload;
		logic                    send_accepted;
		logic                    window_full;
		logic                    last;
	} res_item_t;

endpackage

`default_nettype wire

// File: sv/gbns_ram.sv
// ----------------------------------------------------------------------------
// gbns_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gbns_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: sv/go_back_n_sender_unit.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_unit
// Go-Back-N ARQ sender: window control, payload ring in RAM, resend on timeout.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   cmd      in         cmd_valid / cmd_stall  cmd   (gbns_pkg::cmd_item_t)
//   res      out        res_valid / res_stall  res   (gbns_pkg::res_item_t)
//   apb      in         psel / penable/pready  window_size at byte address 0
//
// One command at a time; each accepted command yields a sequence of results:
// send 1..3 results, ack 1..3, timeout 3 + outstanding (up to BUFFER_SLOTS), other 1.
// All results leave through one output register; the resend loop reads one payload
// ring slot per cycle from the RAM unless stalled. Reset clears the window state;
// the ring needs no clearing pass. A stalled result holds the sequencer; the next
// command may be taken while the final status still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module go_back_n_sender_unit #(
	parameter int BUFFER_SLOTS = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// command channel
	input  wire logic                                cmd_valid,
	output logic                                     cmd_stall,
	input  wire gbns_pkg::cmd_item_t                 cmd,
	// result channel
	output logic                                     res_valid,
	input  wire logic                                res_stall,
	output gbns_pkg::res_item_t                      res,
	// configuration port
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [gbns_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [gbns_pkg::APB_DATA_W-1:0]     pwdata,
	output logic      [gbns_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                     pready
);

	import gbns_pkg::*;

	localparam int SLOT_W = (BUFFER_SLOTS > 1) ? $clog2(BUFFER_SLOTS) : 1;
	localparam int CNT_W  = $clog2(BUFFER_SLOTS + 1);
	localparam logic [SLOT_W:0]   SLOTS_V  = (SLOT_W + 1)'(BUFFER_SLOTS);
	localparam logic [SEQ_BITS-1:0] SLOTS_S = SEQ_BITS'(BUFFER_SLOTS);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_STOP   = 6'b000010,
		ST_START  = 6'b000100,
		ST_PKT    = 6'b001000,
		ST_RESEND = 6'b010000,
		ST_STATUS = 6'b100000
	} state_t;

	// ring slot arithmetic: value below twice the slot count
	function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SLOT_W:0] v);
		logic [SLOT_W:0] r;
		r = (v >= SLOTS_V) ? (v - SLOTS_V) : v;
		return r[SLOT_W-1:0];
	endfunction

	state_t                  st_q, st_d;
	logic [WSIZE_BITS-1:0]   wsize_q;
	logic [SEQ_BITS-1:0]     base_q, next_q;
	logic [SLOT_W-1:0]       base_slot_q;
	logic [1:0]              kind_q;
	logic                    accepted_q;
	logic                    restart_q;
	logic [SEQ_BITS-1:0]     stop_seq_q, start_seq_q, pkt_seq_q, rs_seq_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [SLOT_W-1:0]       rs_slot_q;
	logic [CNT_W-1:0]        rs_left_q;
	logic                    res_valid_q;
	res_item_t               res_q;

	logic [SEQ_BITS-1:0]     outs, win, ack_d, ack_next;
	logic                    send_ok, ack_ok, window_full_now, cmd_fire, slot_free;
	logic                    emit;
	res_item_t               emit_item;
	logic [SLOT_W-1:0]       send_slot, ack_slot, rs_slot_next;
	logic [CNT_W-1:0]        resend_cnt;
	logic                    ram_we, ram_re;
	logic [SLOT_W-1:0]       ram_raddr;
	logic [PAYLOAD_BITS-1:0] ram_rdata;
	logic                    cfg_write;

	// ------------------------------------------------------------------------
	// configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_WINDOW_SIZE) ?
		APB_DATA_W'(wsize_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsize_q <= WINDOW_SIZE_RESET;
		end else if (cfg_write && paddr[2] == REG_WINDOW_SIZE) begin
			wsize_q <= pwdata[WSIZE_BITS-1:0];
		end
	end

	// ------------------------------------------------------------------------
	// window arithmetic
	always_comb begin
		if (wsize_q == '0) begin
			win = SEQ_BITS'(1);
		end else if (SEQ_BITS'(wsize_q) > SLOTS_S) begin
			win = SLOTS_S;
		end else begin
			win = SEQ_BITS'(wsize_q);
		end
	end

	assign outs            = next_q - base_q;
	assign send_ok         = outs < win;
	assign window_full_now = outs >= win;
	assign ack_d           = cmd.ack_number - base_q;
	assign ack_next        = cmd.ack_number + SEQ_BITS'(1);
	assign ack_ok          = cmd.ack_checksum_ok && (ack_d < outs);
	assign send_slot       = slot_wrap({1'b0, base_slot_q} + outs[SLOT_W:0]);
	assign ack_slot        = slot_wrap({1'b0, base_slot_q} + ack_d[SLOT_W:0] +
		(SLOT_W + 1)'(1));
	assign rs_slot_next    = slot_wrap({1'b0, rs_slot_q} + (SLOT_W + 1)'(1));
	assign resend_cnt      = (outs > SLOTS_S) ? CNT_W'(BUFFER_SLOTS) : outs[CNT_W-1:0];

	// ------------------------------------------------------------------------
	// handshake
	assign cmd_stall = (st_q != ST_IDLE);
	assign cmd_fire  = cmd_valid && !cmd_stall;
	assign slot_free = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// ------------------------------------------------------------------------
	// sequencer: next state, result to emit, ring reads
	always_comb begin
		st_d      = st_q;
		emit      = 1'b0;
		emit_item = '0;
		ram_re    = 1'b0;
		ram_raddr = base_slot_q;
		case (st_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					case (cmd.kind)
						KIND_SEND: begin
							if (send_ok) begin
								st_d = (outs == '0) ? ST_START : ST_PKT;
							end else begin
								st_d = ST_STATUS;
							end
						end
						KIND_ACK: st_d = ack_ok ? ST_STOP : ST_STATUS;
						KIND_TIMEOUT: st_d = ST_STOP;
						default: st_d = ST_STATUS;
					endcase
				end
			end
			ST_STOP: begin
				emit                 = 1'b1;
				emit_item.item_kind  = RES_TSTOP;
				emit_item.seq_number = stop_seq_q;
				if (slot_free) begin
					if (kind_q == KIND_ACK && !restart_q) begin
						st_d = ST_STATUS;
					end else begin
						st_d = ST_START;
					end
				end
			end
			ST_START: begin
				emit                 = 1'b1;
				emit_item.item_kind  = RES_TSTART;
				emit_item.seq_number = start_seq_q;
				if (slot_free) begin
					case (kind_q)
						KIND_SEND: st_d = ST_PKT;
						KIND_TIMEOUT: begin
							if (outs != '0) begin
								st_d      = ST_RESEND;
								ram_re    = 1'b1;
								ram_raddr = base_slot_q;
							end else begin
								st_d = ST_STATUS;
							end
						end
						default: st_d = ST_STATUS;
					endcase
				end
			end
			ST_PKT: begin
				emit                     = 1'b1;
				emit_item.item_kind      = RES_PACKET;
				emit_item.seq_number     = pkt_seq_q;
				emit_item.packet_payload = pay_q;
				if (slot_free) begin
					st_d = ST_STATUS;
				end
			end
			ST_RESEND: begin
				emit                     = 1'b1;
				emit_item.item_kind      = RES_PACKET;
				emit_item.seq_number     = rs_seq_q;
				emit_item.packet_payload = ram_rdata;
				if (slot_free) begin
					if (rs_left_q > CNT_W'(1)) begin
						ram_re    = 1'b1;
						ram_raddr = rs_slot_next;
					end else begin
						st_d = ST_STATUS;
					end
				end
			end
			ST_STATUS: begin
				emit                    = 1'b1;
				emit_item.item_kind     = RES_STATUS;
				emit_item.seq_number    = next_q;
				emit_item.send_accepted = accepted_q;
				emit_item.window_full   = window_full_now;
				emit_item.last          = 1'b1;
				if (slot_free) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	assign ram_we = cmd_fire && (cmd.kind == KIND_SEND) && send_ok;

	// ------------------------------------------------------------------------
	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			base_q      <= '0;
			next_q      <= '0;
			base_slot_q <= '0;
			kind_q      <= KIND_SEND;
			accepted_q  <= 1'b0;
			restart_q   <= 1'b0;
			rs_slot_q   <= '0;
			rs_left_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cmd_fire) begin
				kind_q     <= cmd.kind;
				accepted_q <= ram_we;
				if (ram_we) begin
					next_q <= next_q + SEQ_BITS'(1);
				end
				if (cmd.kind == KIND_ACK && ack_ok) begin
					base_q      <= ack_next;
					base_slot_q <= ack_slot;
					restart_q   <= (ack_next != next_q);
				end
			end
			// resend walk over the ring
			if (st_q == ST_START && ram_re) begin
				rs_slot_q <= base_slot_q;
				rs_left_q <= resend_cnt;
			end else if (st_q == ST_RESEND && ram_re) begin
				rs_slot_q <= rs_slot_next;
				rs_left_q <= rs_left_q - CNT_W'(1);
			end
			// output register
			if (emit && slot_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			case (cmd.kind)
				KIND_SEND: begin
					pkt_seq_q   <= next_q;
					start_seq_q <= next_q;
					pay_q       <= cmd.payload;
				end
				KIND_ACK: begin
					stop_seq_q  <= base_q;
					start_seq_q <= ack_next;
				end
				KIND_TIMEOUT: begin
					stop_seq_q  <= cmd.timeout_seq;
					start_seq_q <= cmd.timeout_seq;
				end
				default: begin
					pay_q <= pay_q;
				end
			endcase
		end
		if (st_q == ST_START && ram_re) begin
			rs_seq_q <= base_q;
		end else if (st_q == ST_RESEND && ram_re) begin
			rs_seq_q <= rs_seq_q + SEQ_BITS'(1);
		end
		if (emit && slot_free) begin
			res_q <= emit_item;
		end
	end

	// ------------------------------------------------------------------------
	// payload ring
	gbns_ram #(
		.WIDTH (PAYLOAD_BITS),
		.DEPTH (BUFFER_SLOTS)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (send_slot),
		.wdata (cmd.payload),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

// File: sv/gbns_checker.sv
// ----------------------------------------------------------------------------
// gbns_checker
// Port-level checks of the Go-Back-N sender, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "go_back_n_sender_unit_assert.svh"

module gbns_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                cmd_valid,
	input wire logic                cmd_stall,
	input wire logic                res_valid,
	input wire logic                res_stall,
	input wire gbns_pkg::res_item_t res
);

	import gbns_pkg::*;

	// a stalled result stays put
	`GBNS_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))

	// one command at a time: a transfer on cmd closes the channel
	`GBNS_ASSERT_NEXT(a_cmd_busy, cmd_valid && !cmd_stall, cmd_stall)

	// only the status closes the results of a command
	`GBNS_ASSERT_NOW(a_last_status, res_valid,
		res.last == (res.item_kind == RES_STATUS))

	// status flags stay clear outside the status
	`GBNS_ASSERT_NOW(a_flags_status, res_valid && res.item_kind != RES_STATUS,
		!res.send_accepted && !res.window_full)

endmodule

bind go_back_n_sender_unit gbns_checker u_gbns_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

`default_nettype wire
